### sv/crc_checked_command_frame_receiver_top_defines.svh
// Assertion macros shared by the command frame receiver modules.
`ifndef CRC_CHECKED_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CRC_CHECKED_COMMAND_FRAME_RECEIVER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CCFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccfr check failed");

// Check that cons holds in the cycle after ante.
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccfr check failed");

`endif

### sv/ccfr_pkg.sv
// Types, codes and the CRC step shared by the command frame receiver.
package ccfr_pkg;

   // Input beat kinds
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Command codes carried in the first frame byte
   localparam logic [7:0] CODE_READ    = 8'd45;
   localparam logic [7:0] CODE_PROGRAM = 8'd94;
   localparam logic [7:0] CODE_STOP    = 8'd147;
   localparam logic [7:0] CODE_RESET   = 8'd224;

   // CRC-16/XMODEM generator polynomial
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Payload bytes shown on the result channel
   localparam int OUT_PAYLOAD_BYTES = 16;

   typedef enum logic [2:0] {
      STATUS_CRC_ERROR = 3'd0,
      STATUS_READ      = 3'd1,
      STATUS_PROGRAM   = 3'd2,
      STATUS_STOP      = 3'd3,
      STATUS_RESET     = 3'd4,
      STATUS_UNKNOWN   = 3'd5
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] target_address;
      logic [63:0] payload_low;
      logic [63:0] payload_high;
   } result_type;

   // Advance the CRC by one byte, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### sv/ccfr_req_if.sv
// Request channel: serial byte or timeout beats.
interface ccfr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

### sv/ccfr_rsp_if.sv
// Response channel: one decoded result per completed frame.
interface ccfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] target_address;
   logic [63:0] payload_low;
   logic [63:0] payload_high;

   modport source (output valid, output status, output target_address,
                   output payload_low, output payload_high, input ready);
   modport sink   (input valid, input status, input target_address,
                   input payload_low, input payload_high, output ready);
endinterface

### sv/ccfr_frame.sv
// Input register, frame assembly, running CRC and command decode.
`include "crc_checked_command_frame_receiver_top_defines.svh"

module ccfr_frame #(
   parameter int PAYLOAD_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   ccfr_req_if.sink             req,
   input  logic                 out_ready,
   output logic                 res_valid,
   output ccfr_pkg::result_type res
);

   localparam int FRAME_BYTES = PAYLOAD_BYTES + 5;
   localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W       = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [COUNT_W-1:0] POS_ADDR_LOW  = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] POS_ADDR_HIGH = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] POS_PAYLOAD   = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] POS_CHECK_LOW = COUNT_W'(FRAME_BYTES - 2);
   localparam logic [COUNT_W-1:0] POS_LAST      = COUNT_W'(FRAME_BYTES - 1);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT   = COUNT_W'(FRAME_BYTES);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff, in_cmd_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Frame state
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         command_ff;
   logic [15:0]        address_ff;
   logic [7:0]         payload_ff [PAYLOAD_BYTES];
   logic [7:0]         check_low_ff;

   logic               advance;
   logic               byte_beat;
   logic [COUNT_W-1:0] pos;
   logic [15:0]        crc_next;
   logic [IDX_W-1:0]   payload_idx;
   logic               wr_command, wr_addr_low, wr_addr_high, wr_payload, wr_check_low;
   logic [15:0]        received_crc;
   logic [8*ccfr_pkg::OUT_PAYLOAD_BYTES-1:0] payload_flat;
   ccfr_pkg::status_type command_status;

   // Take a new beat whenever the input register is empty or the held one moves on
   assign advance   = in_valid_ff && out_ready;
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_cmd_in   = in_cmd_ff;
      in_byte_in  = in_byte_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
         in_cmd_in   = req.cmd;
         in_byte_in  = req.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_cmd_ff  <= in_cmd_in;
      in_byte_ff <= in_byte_in;
   end

   // Locate the held byte in the frame
   assign byte_beat   = advance && (in_cmd_ff == ccfr_pkg::CMD_BYTE);
   assign pos         = (count_ff >= COUNT_LIMIT) ? '0 : count_ff;
   assign crc_next    = ccfr_pkg::crc16_byte((pos == '0) ? 16'h0000 : crc_ff, in_byte_ff);
   assign payload_idx = IDX_W'(pos - POS_PAYLOAD);

   assign wr_command   = byte_beat && (pos == '0);
   assign wr_addr_low  = byte_beat && (pos == POS_ADDR_LOW);
   assign wr_addr_high = byte_beat && (pos == POS_ADDR_HIGH);
   assign wr_payload   = byte_beat && (pos >= POS_PAYLOAD) && (pos < POS_CHECK_LOW);
   assign wr_check_low = byte_beat && (pos == POS_CHECK_LOW);

   // Advance the byte count and running CRC; restart after the last byte, drop the frame on timeout
   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (advance) begin
         if (in_cmd_ff == ccfr_pkg::CMD_TIMEOUT) begin
            count_in = '0;
            crc_in   = '0;
         end else if (pos == POS_LAST) begin
            count_in = '0;
            crc_in   = '0;
         end else begin
            count_in = pos + COUNT_W'(1);
            if (pos != POS_CHECK_LOW) begin
               crc_in = crc_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= '0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   // Store the frame fields
   always_ff @(posedge clock) begin
      if (wr_command) begin
         command_ff <= in_byte_ff;
      end
      if (wr_addr_low) begin
         address_ff[7:0] <= in_byte_ff;
      end
      if (wr_addr_high) begin
         address_ff[15:8] <= in_byte_ff;
      end
      if (wr_payload) begin
         payload_ff[payload_idx] <= in_byte_ff;
      end
      if (wr_check_low) begin
         check_low_ff <= in_byte_ff;
      end
   end

   // Gather the visible payload bytes, zero past the payload size
   for (genvar k = 0; k < ccfr_pkg::OUT_PAYLOAD_BYTES; k++) begin : g_pack
      if (k < PAYLOAD_BYTES) begin : g_byte
         assign payload_flat[8*k +: 8] = payload_ff[k];
      end else begin : g_zero
         assign payload_flat[8*k +: 8] = 8'h00;
      end
   end

   // Decode the command code
   always_comb begin
      case (command_ff)
         ccfr_pkg::CODE_READ:    command_status = ccfr_pkg::STATUS_READ;
         ccfr_pkg::CODE_PROGRAM: command_status = ccfr_pkg::STATUS_PROGRAM;
         ccfr_pkg::CODE_STOP:    command_status = ccfr_pkg::STATUS_STOP;
         ccfr_pkg::CODE_RESET:   command_status = ccfr_pkg::STATUS_RESET;
         default:                command_status = ccfr_pkg::STATUS_UNKNOWN;
      endcase
   end

   // Check the received CRC on the last byte and form the result
   assign received_crc = {in_byte_ff, check_low_ff};
   assign res_valid    = byte_beat && (pos == POS_LAST);

   always_comb begin
      if (received_crc == crc_ff) begin
         res.status         = command_status;
         res.target_address = address_ff;
         res.payload_low    = payload_flat[63:0];
         res.payload_high   = payload_flat[127:64];
      end else begin
         res.status         = ccfr_pkg::STATUS_CRC_ERROR;
         res.target_address = '0;
         res.payload_low    = '0;
         res.payload_high   = '0;
      end
   end

   `CCFR_ASSERT_SAME(a_count_in_frame, clock, reset, 1'b1, count_ff < COUNT_LIMIT)
   `CCFR_ASSERT_NEXT(a_result_restarts_frame, clock, reset, res_valid,
                     count_ff == '0 && crc_ff == 16'h0000)
   `CCFR_ASSERT_NEXT(a_timeout_drops_frame, clock, reset,
                     advance && in_cmd_ff == ccfr_pkg::CMD_TIMEOUT,
                     count_ff == '0 && crc_ff == 16'h0000)

endmodule

### sv/ccfr_skid.sv
// Result register with a skid stage in front of the response channel.
`include "crc_checked_command_frame_receiver_top_defines.svh"

module ccfr_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 d_valid,
   input  ccfr_pkg::result_type d,
   output logic                 d_ready,
   ccfr_rsp_if.source           rsp
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   ccfr_pkg::result_type main_ff, main_in;
   ccfr_pkg::result_type skid_ff, skid_in;
   logic                 take;

   assign take    = main_valid_ff && rsp.ready;
   assign d_ready = !skid_valid_ff;

   // Refill the result register from the skid first, then from the new beat
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = d_valid;
            main_in       = d;
         end
      end else if (d_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid          = main_valid_ff;
   assign rsp.status         = main_ff.status;
   assign rsp.target_address = main_ff.target_address;
   assign rsp.payload_low    = main_ff.payload_low;
   assign rsp.payload_high   = main_ff.payload_high;

   `CCFR_ASSERT_SAME(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `CCFR_ASSERT_NEXT(a_main_holds, clock, reset, main_valid_ff && !rsp.ready,
                     main_valid_ff && $stable(main_ff))
   `CCFR_ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && !rsp.ready,
                     skid_valid_ff && $stable(skid_ff))

endmodule

### sv/crc_checked_command_frame_receiver_top.sv
// Top level of the CRC-checked command frame receiver.
//
// req carries one beat per serial event: cmd 0 with rx_byte for a received
// byte, cmd 1 for an inter-byte timeout, which drops any partial frame.
// A frame is PAYLOAD_BYTES + 5 bytes: command, address (low byte first),
// payload, then a CRC-16/XMODEM over all earlier bytes, low byte first.
// The last byte of a frame gives one beat on rsp: status 0 for a CRC
// mismatch (address and payload zero), else the decoded command with the
// address and the first 16 payload bytes; no other beat gives a result.
// Throughput is one req beat per cycle while the skid stage has room; the per-byte CRC step is a single
// unrolled 8-bit update between the input register and the frame state.
// After the final byte is accepted it sits in the input register, then the
// result moves to the result register, which drives rsp.valid.
// While rsp is stalled the result register holds and a skid stage takes
// one more result; req.ready drops only when the skid stage is also full.
// Synchronous reset empties both registers and restarts frame assembly.
module crc_checked_command_frame_receiver_top #(
   parameter int PAYLOAD_BYTES = 16
) (
   input  logic       clock,
   input  logic       reset,
   ccfr_req_if.sink   req,
   ccfr_rsp_if.source rsp
);

   logic                 res_valid;
   logic                 res_ready;
   ccfr_pkg::result_type res;

   // Assemble frames and decode the command
   ccfr_frame #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_ready (res_ready),
      .res_valid (res_valid),
      .res       (res)
   );

   // Hold results for the response channel
   ccfr_skid u_skid (
      .clock   (clock),
      .reset   (reset),
      .d_valid (res_valid),
      .d       (res),
      .d_ready (res_ready),
      .rsp     (rsp)
   );

endmodule
